FILE: sv/wlqe_pkg.sv
// Shared types and constants for the wide line quad expander.
// No dependencies; imported by every module of the block.
`default_nettype none

package wlqe_pkg;

   localparam int COORD_W              = 16;
   localparam int DIFF_W               = COORD_W + 1;
   localparam int COORD_FRAC_BITS_DEF  = 14;
   localparam int COORD_FRAC_BITS_MIN  = 8;
   localparam int COORD_FRAC_BITS_MAX  = 20;
   localparam int LEN_EXTRA_BITS       = 14;
   localparam int UNIT_FRAC_BITS       = 16;
   localparam int WIDTH_FRAC_BITS      = 8;
   localparam int WIDTH_DIV            = 50;
   localparam int HALF_DIV             = WIDTH_DIV / 2;

   localparam int SQ_W   = 2 * DIFF_W;
   localparam int RAD_W  = SQ_W + 2 * LEN_EXTRA_BITS;
   localparam int LEN_W  = RAD_W / 2;
   localparam int NUM_SH = LEN_EXTRA_BITS + UNIT_FRAC_BITS;
   localparam int DIV_W  = LEN_W + UNIT_FRAC_BITS + 2;
   localparam int Q_W    = UNIT_FRAC_BITS + 1;
   localparam int PROD_W = COORD_W + Q_W;

   localparam int QDEPTH = 4;
   localparam int QA_W   = $clog2(QDEPTH);

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic [COORD_W-1:0]        line_width;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic                      degen;
   } seg_type;

   typedef struct packed {
      seg_type         seg;
      logic [SQ_W-1:0] sq;
   } entry_type;

endpackage

`default_nettype wire

FILE: sv/wide_line_quad_expander.sv
// Thick line quad expander: one segment in, four corners out.
// Throughput: one item per cycle while the output is not stalled; the rate is set
// by the pipelined square root and dividers.
// Reset: synchronous, clears pipeline valid bits and queue pointers and count only.
// Depends on wlqe_pkg, wlqe_front, wlqe_queue, wlqe_back.
`default_nettype none

module wide_line_quad_expander
   import wlqe_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   input  wire logic [COORD_W-1:0]        req_line_width,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [COORD_W-1:0]      rsp_start_left_x,
   output logic signed [COORD_W-1:0]      rsp_start_left_y,
   output logic signed [COORD_W-1:0]      rsp_start_right_x,
   output logic signed [COORD_W-1:0]      rsp_start_right_y,
   output logic signed [COORD_W-1:0]      rsp_end_left_x,
   output logic signed [COORD_W-1:0]      rsp_end_left_y,
   output logic signed [COORD_W-1:0]      rsp_end_right_x,
   output logic signed [COORD_W-1:0]      rsp_end_right_y,
   output logic                           rsp_degenerate,
   output logic                           rsp_clipped
);

   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop;
   entry_type pop_data;

   wlqe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_line_width(req_line_width),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .push_ready    (push_ready)
   );

   wlqe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_ready(push_ready),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop)
   );

   wlqe_back #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (pop_valid),
      .q_data           (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_start_left_x (rsp_start_left_x),
      .rsp_start_left_y (rsp_start_left_y),
      .rsp_start_right_x(rsp_start_right_x),
      .rsp_start_right_y(rsp_start_right_y),
      .rsp_end_left_x   (rsp_end_left_x),
      .rsp_end_left_y   (rsp_end_left_y),
      .rsp_end_right_x  (rsp_end_right_x),
      .rsp_end_right_y  (rsp_end_right_y),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_clipped      (rsp_clipped)
   );

endmodule

`default_nettype wire

FILE: sv/wlqe_front.sv
// Front end: accepts segments, forms the direction and its squared length.
// Depends on wlqe_pkg.
`default_nettype none

module wlqe_front
   import wlqe_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_end_x,
   input  wire logic signed [COORD_W-1:0] req_end_y,
   input  wire logic [COORD_W-1:0]        req_line_width,
   output logic                           push_valid,
   output entry_type                      push_data,
   input  wire logic                      push_ready
);

   logic     valid_ff;
   seg_type  seg_ff;
   seg_type  seg_in;
   logic     take;
   logic signed [SQ_W-1:0] sqx;
   logic signed [SQ_W-1:0] sqy;

   assign take      = !valid_ff || push_ready;
   assign req_stall = !take;

   always_comb begin
      seg_in.start_x    = req_start_x;
      seg_in.start_y    = req_start_y;
      seg_in.end_x      = req_end_x;
      seg_in.end_y      = req_end_y;
      seg_in.line_width = req_line_width;
      seg_in.dx         = DIFF_W'(req_start_x) - DIFF_W'(req_end_x);
      seg_in.dy         = DIFF_W'(req_start_y) - DIFF_W'(req_end_y);
      seg_in.degen      = (req_start_x == req_end_x) && (req_start_y == req_end_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= req_valid;
      end
      if (take && req_valid) begin
         seg_ff <= seg_in;
      end
   end

   always_comb begin
      sqx = seg_ff.dx * seg_ff.dx;
      sqy = seg_ff.dy * seg_ff.dy;
      push_data.seg = seg_ff;
      push_data.sq  = $unsigned(sqx) + $unsigned(sqy);
   end

   assign push_valid = valid_ff;

endmodule

`default_nettype wire

FILE: sv/wlqe_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on wlqe_pkg.
`default_nettype none

module wlqe_queue
   import wlqe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire entry_type push_data,
   output logic           push_ready,
   output logic           pop_valid,
   output entry_type      pop_data,
   input  wire logic      pop
);

   entry_type         slot_ff [QDEPTH];
   logic [QA_W-1:0]   wr_ptr_ff;
   logic [QA_W-1:0]   rd_ptr_ff;
   logic [QA_W:0]     count_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != (QA_W+1)'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/wlqe_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on wlqe_pkg; used by wlqe_back.
`default_nettype none

module wlqe_sqrt
   import wlqe_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_valid,
   input  wire logic [SQ_W-1:0] in_sq,
   input  wire seg_type         in_seg,
   output logic                 out_valid,
   output logic [LEN_W-1:0]     out_len,
   output seg_type              out_seg
);

   logic [RAD_W-1:0] rem_ff  [0:LEN_W];
   logic [LEN_W-1:0] root_ff [0:LEN_W];
   logic             valid_ff[0:LEN_W];
   seg_type          seg_ff  [0:LEN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
      if (adv) begin
         rem_ff[0]  <= {in_sq, {(2*LEN_EXTRA_BITS){1'b0}}};
         root_ff[0] <= '0;
         seg_ff[0]  <= in_seg;
      end
   end

   for (genvar k = 0; k < LEN_W; k++) begin : g_step
      localparam int B = LEN_W - 1 - k;
      logic [RAD_W:0]   trial;
      logic [RAD_W-1:0] rem_in;
      logic [LEN_W-1:0] root_in;

      always_comb begin
         trial = ((RAD_W+1)'(root_ff[k]) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_in  = rem_ff[k] - trial[RAD_W-1:0];
            root_in = root_ff[k] | (LEN_W'(1) << B);
         end else begin
            rem_in  = rem_ff[k];
            root_in = root_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (adv) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            seg_ff[k+1]  <= seg_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[LEN_W];
   assign out_len   = root_ff[LEN_W];
   assign out_seg   = seg_ff[LEN_W];

endmodule

`default_nettype wire

FILE: sv/wlqe_back.sv
// Back end: length, unit vector division, width scaling and corner saturation.
// Depends on wlqe_pkg and wlqe_sqrt.
`default_nettype none

module wlqe_back
   import wlqe_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire entry_type          q_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [COORD_W-1:0] rsp_start_left_x,
   output logic signed [COORD_W-1:0] rsp_start_left_y,
   output logic signed [COORD_W-1:0] rsp_start_right_x,
   output logic signed [COORD_W-1:0] rsp_start_right_y,
   output logic signed [COORD_W-1:0] rsp_end_left_x,
   output logic signed [COORD_W-1:0] rsp_end_left_y,
   output logic signed [COORD_W-1:0] rsp_end_right_x,
   output logic signed [COORD_W-1:0] rsp_end_right_y,
   output logic                    rsp_degenerate,
   output logic                    rsp_clipped
);

   localparam int K    = WIDTH_FRAC_BITS + UNIT_FRAC_BITS - COORD_FRAC_BITS;
   localparam int YW   = PROD_W - K;
   localparam int SH   = YW + 5;
   localparam int MW   = SH - 4;
   localparam int QEW  = YW - 4;
   localparam int OW   = QEW + 1;
   localparam int CW   = ((OW > COORD_W) ? OW : COORD_W) + 1;
   localparam logic [63:0] RECIP_FULL = (64'd1 << SH) / HALF_DIV;
   localparam logic signed [CW-1:0] SAT_MAX = CW'(32767);
   localparam logic signed [CW-1:0] SAT_MIN = -CW'(32768);
   localparam logic [Q_W-1:0] UNIT_ONE = Q_W'(1) << UNIT_FRAC_BITS;

   logic adv;
   logic rsp_valid_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && q_valid;

   logic             sq_valid;
   logic [LEN_W-1:0] sq_len;
   seg_type          sq_seg;

   wlqe_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (q_valid),
      .in_sq    (q_data.sq),
      .in_seg   (q_data.seg),
      .out_valid(sq_valid),
      .out_len  (sq_len),
      .out_seg  (sq_seg)
   );

   // unit vector division
   logic [DIV_W-1:0] rx_ff   [0:Q_W];
   logic [DIV_W-1:0] ry_ff   [0:Q_W];
   logic [Q_W-1:0]   qx_ff   [0:Q_W];
   logic [Q_W-1:0]   qy_ff   [0:Q_W];
   logic [LEN_W-1:0] dlen_ff [0:Q_W];
   logic             dvalid_ff[0:Q_W];
   seg_type          dseg_ff [0:Q_W];
   logic [DIFF_W-1:0] abs_x;
   logic [DIFF_W-1:0] abs_y;

   always_comb begin
      abs_x = sq_seg.dx[DIFF_W-1] ? -sq_seg.dx : sq_seg.dx;
      abs_y = sq_seg.dy[DIFF_W-1] ? -sq_seg.dy : sq_seg.dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff[0] <= 1'b0;
      end else if (adv) begin
         dvalid_ff[0] <= sq_valid;
      end
      if (adv) begin
         rx_ff[0]   <= (DIV_W'(abs_x[COORD_W-1:0]) << NUM_SH) + DIV_W'(sq_len >> 1);
         ry_ff[0]   <= (DIV_W'(abs_y[COORD_W-1:0]) << NUM_SH) + DIV_W'(sq_len >> 1);
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         dlen_ff[0] <= sq_len;
         dseg_ff[0] <= sq_seg;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      localparam int B = Q_W - 1 - k;
      logic [DIV_W-1:0] divisor;
      logic [DIV_W-1:0] rx_in;
      logic [DIV_W-1:0] ry_in;
      logic [Q_W-1:0]   qx_in;
      logic [Q_W-1:0]   qy_in;

      always_comb begin
         divisor = DIV_W'(dlen_ff[k]) << B;
         rx_in   = rx_ff[k];
         qx_in   = qx_ff[k];
         ry_in   = ry_ff[k];
         qy_in   = qy_ff[k];
         if (rx_ff[k] >= divisor) begin
            rx_in = rx_ff[k] - divisor;
            qx_in = qx_ff[k] | (Q_W'(1) << B);
         end
         if (ry_ff[k] >= divisor) begin
            ry_in = ry_ff[k] - divisor;
            qy_in = qy_ff[k] | (Q_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dvalid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dvalid_ff[k+1] <= dvalid_ff[k];
         end
         if (adv) begin
            rx_ff[k+1]   <= rx_in;
            ry_ff[k+1]   <= ry_in;
            qx_ff[k+1]   <= qx_in;
            qy_ff[k+1]   <= qy_in;
            dlen_ff[k+1] <= dlen_ff[k];
            dseg_ff[k+1] <= dseg_ff[k];
         end
      end
   end

   // width scaling: product, reciprocal estimate, correction
   logic [Q_W-1:0]    ux;
   logic [Q_W-1:0]    uy;
   logic              mvalid_ff;
   logic [PROD_W-1:0] px_ff;
   logic [PROD_W-1:0] py_ff;
   seg_type           mseg_ff;

   assign ux = (qx_ff[Q_W] > UNIT_ONE) ? UNIT_ONE : qx_ff[Q_W];
   assign uy = (qy_ff[Q_W] > UNIT_ONE) ? UNIT_ONE : qy_ff[Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         mvalid_ff <= 1'b0;
      end else if (adv) begin
         mvalid_ff <= dvalid_ff[Q_W];
      end
      if (adv) begin
         px_ff   <= PROD_W'(dseg_ff[Q_W].line_width) * PROD_W'(ux);
         py_ff   <= PROD_W'(dseg_ff[Q_W].line_width) * PROD_W'(uy);
         mseg_ff <= dseg_ff[Q_W];
      end
   end

   logic [PROD_W:0]   xsum_x;
   logic [PROD_W:0]   xsum_y;
   logic [YW-1:0]     yx;
   logic [YW-1:0]     yy;
   logic [YW+MW-1:0]  rpx;
   logic [YW+MW-1:0]  rpy;
   logic              rvalid_ff;
   logic [YW-1:0]     yx_ff;
   logic [YW-1:0]     yy_ff;
   logic [QEW-1:0]    qex_ff;
   logic [QEW-1:0]    qey_ff;
   seg_type           rseg_ff;

   always_comb begin
      xsum_x = {1'b0, px_ff} + ((PROD_W+1)'(HALF_DIV) << K);
      xsum_y = {1'b0, py_ff} + ((PROD_W+1)'(HALF_DIV) << K);
      yx     = xsum_x[PROD_W:K+1];
      yy     = xsum_y[PROD_W:K+1];
      rpx    = (YW+MW)'(yx) * (YW+MW)'(RECIP_FULL[MW-1:0]);
      rpy    = (YW+MW)'(yy) * (YW+MW)'(RECIP_FULL[MW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (adv) begin
         rvalid_ff <= mvalid_ff;
      end
      if (adv) begin
         yx_ff   <= yx;
         yy_ff   <= yy;
         qex_ff  <= rpx[SH +: QEW];
         qey_ff  <= rpy[SH +: QEW];
         rseg_ff <= mseg_ff;
      end
   end

   logic [YW-1:0]  remx;
   logic [YW-1:0]  remy;
   logic           cvalid_ff;
   logic [QEW-1:0] magx_ff;
   logic [QEW-1:0] magy_ff;
   seg_type        cseg_ff;

   always_comb begin
      remx = yx_ff - YW'(qex_ff) * YW'(HALF_DIV);
      remy = yy_ff - YW'(qey_ff) * YW'(HALF_DIV);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= 1'b0;
      end else if (adv) begin
         cvalid_ff <= rvalid_ff;
      end
      if (adv) begin
         magx_ff <= qex_ff + QEW'(remx >= YW'(HALF_DIV));
         magy_ff <= qey_ff + QEW'(remy >= YW'(HALF_DIV));
         cseg_ff <= rseg_ff;
      end
   end

   // corners and saturation
   function automatic logic [COORD_W:0] sat_corner(input logic signed [CW-1:0] v);
      logic [COORD_W:0] res;
      if (v > SAT_MAX) begin
         res = {1'b1, 16'h7fff};
      end else if (v < SAT_MIN) begin
         res = {1'b1, 16'h8000};
      end else begin
         res = {1'b0, v[COORD_W-1:0]};
      end
      return res;
   endfunction

   logic signed [OW-1:0] ox;
   logic signed [OW-1:0] oy;
   logic signed [CW-1:0] osx;
   logic signed [CW-1:0] osy;
   logic [COORD_W:0]     c_slx, c_sly, c_srx, c_sry, c_elx, c_ely, c_erx, c_ery;

   always_comb begin
      if (cseg_ff.degen) begin
         ox = '0;
         oy = '0;
      end else begin
         ox = cseg_ff.dx[DIFF_W-1] ? -$signed({1'b0, magx_ff}) : $signed({1'b0, magx_ff});
         oy = cseg_ff.dy[DIFF_W-1] ? -$signed({1'b0, magy_ff}) : $signed({1'b0, magy_ff});
      end
      osx   = CW'(ox);
      osy   = CW'(oy);
      c_slx = sat_corner(CW'(cseg_ff.start_x) + osy);
      c_sly = sat_corner(CW'(cseg_ff.start_y) - osx);
      c_srx = sat_corner(CW'(cseg_ff.start_x) - osy);
      c_sry = sat_corner(CW'(cseg_ff.start_y) + osx);
      c_elx = sat_corner(CW'(cseg_ff.end_x) + osy);
      c_ely = sat_corner(CW'(cseg_ff.end_y) - osx);
      c_erx = sat_corner(CW'(cseg_ff.end_x) - osy);
      c_ery = sat_corner(CW'(cseg_ff.end_y) + osx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cvalid_ff;
      end
      if (adv) begin
         rsp_start_left_x  <= c_slx[COORD_W-1:0];
         rsp_start_left_y  <= c_sly[COORD_W-1:0];
         rsp_start_right_x <= c_srx[COORD_W-1:0];
         rsp_start_right_y <= c_sry[COORD_W-1:0];
         rsp_end_left_x    <= c_elx[COORD_W-1:0];
         rsp_end_left_y    <= c_ely[COORD_W-1:0];
         rsp_end_right_x   <= c_erx[COORD_W-1:0];
         rsp_end_right_y   <= c_ery[COORD_W-1:0];
         rsp_degenerate    <= cseg_ff.degen;
         rsp_clipped       <= c_slx[COORD_W] | c_sly[COORD_W] | c_srx[COORD_W] |
                              c_sry[COORD_W] | c_elx[COORD_W] | c_ely[COORD_W] |
                              c_erx[COORD_W] | c_ery[COORD_W];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      sq_valid && !sq_seg.degen |-> sq_len != '0)
      else $error("nonzero segment produced zero length");

   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      dvalid_ff[Q_W] && !dseg_ff[Q_W].degen |->
         qx_ff[Q_W] <= UNIT_ONE && qy_ff[Q_W] <= UNIT_ONE)
      else $error("unit component above one");

   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> remx < YW'(WIDTH_DIV) && remy < YW'(WIDTH_DIV))
      else $error("reciprocal estimate off by more than one");

   a_degen_noclip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_clipped &&
         rsp_start_left_x == rsp_start_right_x && rsp_end_left_y == rsp_end_right_y)
      else $error("degenerate segment with nonzero offset");

   a_pop_adv: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !pop)
      else $error("queue popped while output held");

endmodule

`default_nettype wire
